// ----- hw/rtl/zcpq_pkg.sv -----
package zcpq_pkg;

	// field and counter widths
	localparam int TIMER_BITS  = 16;
	localparam int STABLE_BITS = 8;
	localparam int HP_BITS     = 16;
	localparam int QUOT_BITS   = 16;
	localparam int CNT_BITS    = $clog2(QUOT_BITS);
	localparam int ADDR_BITS   = 4;
	localparam int DATA_BITS   = 32;

	localparam int unsigned TIMER_MAX  = (32'd1 << TIMER_BITS) - 32'd1;
	localparam int unsigned STABLE_MAX = (32'd1 << STABLE_BITS) - 32'd1;

	// 0.1 Hz from a half period in us: 5000000 / gap
	localparam longint unsigned FREQ_NUM = 64'd5000000;
	// top dividend bits form the first partial remainder; a gap at or below
	// this value gives a quotient wider than QUOT_BITS, so it saturates
	localparam logic [HP_BITS-1:0]   DIV_HEAD = HP_BITS'(FREQ_NUM >> QUOT_BITS);
	localparam logic [QUOT_BITS-1:0] DIV_TAIL =
		QUOT_BITS'(FREQ_NUM % (64'd1 << QUOT_BITS));

	// register reset values
	localparam logic [15:0] LOW_WARN_RST  = 16'd8000;
	localparam logic [7:0]  STABLE_RST    = 8'd5;
	localparam logic [15:0] MIN_HP_RST    = 16'd9000;
	localparam logic [15:0] MAX_HP_RST    = 16'd11000;

	// register map, word index
	typedef enum logic [ADDR_BITS-3:0] {
		REG_LOW_WARN      = 2'd0,
		REG_STABLE_NEEDED = 2'd1,
		REG_MIN_HP        = 2'd2,
		REG_MAX_HP        = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [15:0] low_warn;
		logic [7:0]  stable_needed;
		logic [15:0] min_hp;
		logic [15:0] max_hp;
	} cfg_t;

	typedef struct packed {
		logic line_valid;
		logic accepted;
		logic oor;
	} qual_stat_t;

	typedef enum logic {
		ST_IDLE,
		ST_DIV
	} seq_state_t;

endpackage

// ----- hw/rtl/zcpq_div.sv -----
module zcpq_div (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                start,
	input  logic [zcpq_pkg::HP_BITS-1:0]        gap,
	output logic                                done,
	output logic [zcpq_pkg::QUOT_BITS-1:0]      freq
);

	logic                               busy_q;
	logic                               done_q;
	logic [zcpq_pkg::CNT_BITS-1:0]      cnt_q;
	logic [zcpq_pkg::HP_BITS-1:0]       gap_q;
	logic [zcpq_pkg::HP_BITS-1:0]       rem_q;
	logic [zcpq_pkg::QUOT_BITS-1:0]     tail_q;
	logic [zcpq_pkg::QUOT_BITS-1:0]     quot_q;
	logic                               sat_q;

	logic [zcpq_pkg::HP_BITS:0]         trial;
	logic [zcpq_pkg::HP_BITS:0]         diff;
	logic                               fits;
	logic [zcpq_pkg::HP_BITS-1:0]       rem_nx;
	logic                               last;

	// one restoring step: bring in the next dividend bit, try the subtract
	always_comb begin
		trial  = {rem_q, tail_q[zcpq_pkg::QUOT_BITS-1]};
		diff   = trial - {1'b0, gap_q};
		fits   = trial >= {1'b0, gap_q};
		rem_nx = fits ? diff[zcpq_pkg::HP_BITS-1:0] : trial[zcpq_pkg::HP_BITS-1:0];
		last   = cnt_q == zcpq_pkg::CNT_BITS'(zcpq_pkg::QUOT_BITS - 1);
	end

	// step counter and completion pulse
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (last) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// remainder, dividend and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			gap_q  <= gap;
			rem_q  <= zcpq_pkg::DIV_HEAD;
			tail_q <= zcpq_pkg::DIV_TAIL;
			quot_q <= '0;
			sat_q  <= gap <= zcpq_pkg::DIV_HEAD;
		end else if (busy_q) begin
			rem_q  <= rem_nx;
			tail_q <= {tail_q[zcpq_pkg::QUOT_BITS-2:0], 1'b0};
			quot_q <= {quot_q[zcpq_pkg::QUOT_BITS-2:0], fits};
		end
	end

	assign done = done_q;
	assign freq = sat_q ? '1 : quot_q;

endmodule

// ----- hw/rtl/zcpq_qual.sv -----
module zcpq_qual (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            tick,
	input  logic                            edge_req,
	input  zcpq_pkg::cfg_t                  cfg,
	output zcpq_pkg::qual_stat_t            stat,
	output logic [zcpq_pkg::HP_BITS-1:0]    hp_latched,
	output logic                            div_start,
	output logic [zcpq_pkg::HP_BITS-1:0]    div_gap
);

	logic                                   seen_q;
	logic                                   running_q;
	logic [zcpq_pkg::TIMER_BITS-1:0]        elapsed_q;
	logic [zcpq_pkg::STABLE_BITS-1:0]       stable_q;
	logic                                   valid_q;
	logic [zcpq_pkg::HP_BITS-1:0]           half_q;
	logic                                   acc_q;
	logic                                   oor_q;

	logic [31:0]                            lim32;
	logic [zcpq_pkg::TIMER_BITS-1:0]        lim;
	logic [zcpq_pkg::TIMER_BITS-1:0]        gap;
	logic [zcpq_pkg::TIMER_BITS-1:0]        el_d;
	logic                                   run_d;
	logic                                   seen_d;
	logic                                   val_d;
	logic [zcpq_pkg::STABLE_BITS-1:0]       sc_d;
	logic [zcpq_pkg::HP_BITS-1:0]           half_d;
	logic                                   acc_d;
	logic                                   oor_d;

	// timer step, then edge qualification on this tick's timer value
	always_comb begin
		lim32  = (32'(cfg.max_hp) < zcpq_pkg::TIMER_MAX) ? 32'(cfg.max_hp)
		                                                 : zcpq_pkg::TIMER_MAX;
		lim    = lim32[zcpq_pkg::TIMER_BITS-1:0];
		gap    = elapsed_q;
		run_d  = running_q;
		val_d  = valid_q;
		seen_d = seen_q;
		sc_d   = stable_q;
		half_d = half_q;
		acc_d  = 1'b0;
		oor_d  = 1'b0;

		if (running_q) begin
			if (gap < lim)
				gap = gap + 1'b1;
			if (gap >= lim) begin
				run_d = 1'b0;
				val_d = 1'b0;
			end
		end
		el_d = gap;

		if (edge_req) begin
			if (!seen_q) begin
				seen_d = 1'b1;
			end else if (32'(gap) >= 32'(cfg.low_warn)) begin
				if (32'(stable_q) < zcpq_pkg::STABLE_MAX)
					sc_d = stable_q + 1'b1;
				if (32'(sc_d) >= 32'(cfg.stable_needed)) begin
					sc_d  = zcpq_pkg::STABLE_BITS'(cfg.stable_needed);
					val_d = 1'b1;
				end
				if (32'(gap) >= 32'(cfg.min_hp) && 32'(gap) <= 32'(cfg.max_hp)) begin
					half_d = zcpq_pkg::HP_BITS'(gap);
					acc_d  = 1'b1;
				end else begin
					oor_d = 1'b1;
				end
			end else begin
				sc_d  = '0;
				val_d = 1'b0;
			end
			el_d  = '0;
			run_d = 1'b1;
		end
	end

	// line state, updated once per accepted tick
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_q    <= 1'b0;
			running_q <= 1'b0;
			elapsed_q <= '0;
			stable_q  <= '0;
			valid_q   <= 1'b0;
			half_q    <= '0;
			acc_q     <= 1'b0;
			oor_q     <= 1'b0;
		end else if (tick) begin
			seen_q    <= seen_d;
			running_q <= run_d;
			elapsed_q <= el_d;
			stable_q  <= sc_d;
			valid_q   <= val_d;
			half_q    <= half_d;
			acc_q     <= acc_d;
			oor_q     <= oor_d;
		end
	end

	assign stat        = '{line_valid: valid_q, accepted: acc_q, oor: oor_q};
	assign hp_latched  = half_q;
	assign div_start   = tick & acc_d;
	assign div_gap     = half_d;

endmodule

// ----- hw/rtl/zero_cross_period_qualifier_unit.sv -----
// Mains zero-crossing half-period qualifier. Each input word is one
// microsecond tick carrying edge_req; each accepted word gives exactly one
// output word with the line validity, the last accepted half period and its
// frequency in 0.1 Hz. A tick that does not latch a new half period is
// answered in the cycle after it is taken, so such ticks can stream at one
// per cycle while out_ready is high. A tick whose edge gives an in-range
// half period starts the bit-serial divider (5000000 / gap, one quotient
// bit per cycle, 16 steps); its output word appears once the divider is
// done, and no tick is taken while the divider runs. Thresholds are set
// through the register port at 0x0 low_warn_us, 0x4 stable_needed, 0x8
// min_half_period_us and 0xC max_half_period_us; the user must see they
// are written only while the block is idle; the block does not enforce it.
module zero_cross_period_qualifier_unit (
	input  logic                                clk,
	input  logic                                arst_n,
	// tick channel
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic                                edge_req,
	// result channel
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                line_valid,
	output logic [zcpq_pkg::HP_BITS-1:0]        half_period_us,
	output logic [zcpq_pkg::QUOT_BITS-1:0]      freq_tenth_hz,
	output logic                                period_accepted,
	output logic                                out_of_range,
	// register port
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [zcpq_pkg::ADDR_BITS-1:0]      paddr,
	input  logic [zcpq_pkg::DATA_BITS-1:0]      pwdata,
	output logic [zcpq_pkg::DATA_BITS-1:0]      prdata,
	output logic                                pready
);

	zcpq_pkg::cfg_t                     cfg_q;
	zcpq_pkg::seq_state_t               state_q;
	zcpq_pkg::seq_state_t               state_d;
	zcpq_pkg::qual_stat_t               stat;
	zcpq_pkg::reg_idx_t                 reg_idx;

	logic                               out_valid_q;
	logic [zcpq_pkg::QUOT_BITS-1:0]     freq_q;
	logic                               tick;
	logic                               wr_en;
	logic                               div_start;
	logic                               div_done;
	logic [zcpq_pkg::HP_BITS-1:0]       div_gap;
	logic [zcpq_pkg::QUOT_BITS-1:0]     div_freq;
	logic [zcpq_pkg::HP_BITS-1:0]       hp_latched;

	// register access
	assign pready  = 1'b1;
	assign reg_idx = zcpq_pkg::reg_idx_t'(paddr[zcpq_pkg::ADDR_BITS-1:2]);
	assign wr_en   = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.low_warn      <= zcpq_pkg::LOW_WARN_RST;
			cfg_q.stable_needed <= zcpq_pkg::STABLE_RST;
			cfg_q.min_hp        <= zcpq_pkg::MIN_HP_RST;
			cfg_q.max_hp        <= zcpq_pkg::MAX_HP_RST;
		end else if (wr_en) begin
			case (reg_idx)
				zcpq_pkg::REG_LOW_WARN:      cfg_q.low_warn      <= pwdata[15:0];
				zcpq_pkg::REG_STABLE_NEEDED: cfg_q.stable_needed <= pwdata[7:0];
				zcpq_pkg::REG_MIN_HP:        cfg_q.min_hp        <= pwdata[15:0];
				zcpq_pkg::REG_MAX_HP:        cfg_q.max_hp        <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			zcpq_pkg::REG_LOW_WARN:      prdata = 32'(cfg_q.low_warn);
			zcpq_pkg::REG_STABLE_NEEDED: prdata = 32'(cfg_q.stable_needed);
			zcpq_pkg::REG_MIN_HP:        prdata = 32'(cfg_q.min_hp);
			zcpq_pkg::REG_MAX_HP:        prdata = 32'(cfg_q.max_hp);
			default:                     prdata = '0;
		endcase
	end

	// sequencer: next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			zcpq_pkg::ST_IDLE: begin
				if (tick && div_start)
					state_d = zcpq_pkg::ST_DIV;
			end
			zcpq_pkg::ST_DIV: begin
				if (div_done)
					state_d = zcpq_pkg::ST_IDLE;
			end
			default: state_d = zcpq_pkg::ST_IDLE;
		endcase
	end

	// sequencer: outputs
	always_comb begin
		case (state_q)
			zcpq_pkg::ST_IDLE: in_ready = !out_valid_q || out_ready;
			zcpq_pkg::ST_DIV:  in_ready = 1'b0;
			default:           in_ready = 1'b0;
		endcase
	end

	assign tick = in_valid & in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= zcpq_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			freq_q      <= '0;
		end else begin
			state_q     <= state_d;
			out_valid_q <= (tick && !div_start) || div_done || (out_valid_q && !out_ready);
			if (div_done)
				freq_q <= div_freq;
		end
	end

	zcpq_qual u_qual (
		.clk         (clk),
		.arst_n      (arst_n),
		.tick        (tick),
		.edge_req    (edge_req),
		.cfg         (cfg_q),
		.stat        (stat),
		.hp_latched  (hp_latched),
		.div_start   (div_start),
		.div_gap     (div_gap)
	);

	zcpq_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.gap    (div_gap),
		.done   (div_done),
		.freq   (div_freq)
	);

	// result word straight from the state registers
	assign out_valid       = out_valid_q;
	assign line_valid      = stat.line_valid;
	assign half_period_us  = hp_latched;
	assign freq_tenth_hz   = freq_q;
	assign period_accepted = stat.accepted;
	assign out_of_range    = stat.oor;

`ifndef SYNTH
	// no tick is taken while the divider runs
	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == zcpq_pkg::ST_DIV |-> !in_ready)
		else $error("tick taken during division");

	// divider completes only while the sequencer waits for it
	assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == zcpq_pkg::ST_DIV)
		else $error("divider done outside division");

	// a latched period always sends the sequencer into division
	assert property (@(posedge clk) disable iff (!arst_n)
		tick && div_start |=> state_q == zcpq_pkg::ST_DIV && !out_valid_q)
		else $error("division not started");

	// an output word never flags an edge as both accepted and out of range
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(stat.accepted && stat.oor))
		else $error("accepted and out of range together");
`endif

endmodule
